// ----- src/pulse_width_period_capture_assert.svh -----
// assertion macros for the pulse width and period capture block
`ifndef PULSE_WIDTH_PERIOD_CAPTURE_ASSERT_SVH
`define PULSE_WIDTH_PERIOD_CAPTURE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PWPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PWPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pwpc_pkg.sv -----
// shared codes and constants for the pulse width and period capture block
`default_nettype none

package pwpc_pkg;

  // mode register codes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_PULSE = 2'd1;
  localparam logic [1:0] MODE_XCHK  = 2'd2;

  // operation codes of a request
  localparam logic [1:0] OP_EDGE   = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned HELD_W     = 8;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = 5;

endpackage

`default_nettype wire

// ----- src/pulse_width_period_capture.sv -----
// Pulse width and period capture. Edge requests (operation 0), clear requests (operation 2)
// and unused operation codes give no result. A report request (operation 1) walks the
// stored timestamps one pair at a time, loading each pair before adding it, since each
// timestamp store has a single read port, then divides the width and period sums by their
// counts on one shared restoring divider at one quotient bit per cycle. The pairs walked
// number min(rises held, falls held - 1); a mean whose count is zero is zero and skips the
// divider. The block stalls its input until the report is done, longer if the previous
// result still waits downstream. The result sits in an output register, so the next
// request is taken while the result is still waiting downstream. Timestamp stores are not
// cleared; only entries below the counts are ever read.
`default_nettype none

`include "pulse_width_period_capture_assert.svh"

module pulse_width_period_capture
  import pwpc_pkg::*;
#(
  parameter int unsigned SAMPLES = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_wr_en_i,
  input  wire logic [1:0]           cfg_wr_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           operation_i,
  input  wire logic                 fall_edge_i,
  input  wire logic                 rise_edge_i,
  input  wire logic [TS_W-1:0]      timestamp_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [TS_W-1:0]           avg_width_o,
  output logic [TS_W-1:0]           avg_period_o,
  output logic [HELD_W-1:0]         falls_held_o,
  output logic [HELD_W-1:0]         rises_held_o,
  output logic [TS_W-1:0]           crosscheck_falls_o,
  output logic                      capture_done_o
);

  localparam int unsigned FALL_DEPTH = SAMPLES + 1;
  localparam int unsigned RISE_DEPTH = SAMPLES;
  localparam int unsigned CNT_W      = $clog2(SAMPLES + 2);
  localparam int unsigned FA_W       = $clog2(FALL_DEPTH);
  localparam int unsigned RA_W       = (RISE_DEPTH > 1) ? $clog2(RISE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FALL_MAX = CNT_W'(FALL_DEPTH);
  localparam logic [CNT_W-1:0] RISE_MAX = CNT_W'(RISE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD0,
    S_PRIME,
    S_LOAD,
    S_ACC,
    S_DSETUP,
    S_DIV,
    S_FINISH
  } state_e;

  state_e state_q;

  logic [1:0]           mode_q;
  logic [CNT_W-1:0]     fall_cnt_q;
  logic [CNT_W-1:0]     rise_cnt_q;
  logic [TS_W-1:0]      xchk_q;

  logic [CNT_W-1:0]     pairs_q;
  logic [CNT_W-1:0]     idx_q;
  logic [TS_W-1:0]      prev_q;
  logic [TS_W-1:0]      wsum_q;
  logic [TS_W-1:0]      psum_q;
  logic [CNT_W-1:0]     wcnt_q;
  logic [CNT_W-1:0]     pcnt_q;
  logic [TS_W-1:0]      avg_w_q;
  logic [TS_W-1:0]      avg_p_q;

  // shared divider
  logic                 div_sel_q;
  logic [TS_W-1:0]      quo_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     dvsr_q;
  logic [DIV_CNT_W-1:0] bit_cnt_q;

  logic                 out_valid_q;
  logic [TS_W-1:0]      out_w_q;
  logic [TS_W-1:0]      out_p_q;
  logic [HELD_W-1:0]    out_falls_q;
  logic [HELD_W-1:0]    out_rises_q;
  logic [TS_W-1:0]      out_xchk_q;
  logic                 out_done_q;

  // timestamp stores
  logic [TS_W-1:0]      fall_mem [FALL_DEPTH];
  logic [TS_W-1:0]      rise_mem [RISE_DEPTH];
  logic [TS_W-1:0]      fall_rd_q;
  logic [TS_W-1:0]      rise_rd_q;
  logic [FA_W-1:0]      fall_raddr;
  logic [RA_W-1:0]      rise_raddr;
  logic [CNT_W-1:0]     idx_inc;

  logic                 in_acc;
  logic                 fall_take;
  logic                 rise_take;
  logic [CNT_W-1:0]     fall_cnt_n;
  logic [CNT_W-1:0]     pairs_n;
  logic [TS_W-1:0]      w_diff;
  logic [TS_W-1:0]      c_diff;
  logic                 w_pos;
  logic                 c_pos;
  logic [CNT_W:0]       div_shift;
  logic [CNT_W:0]       div_trial;
  logic                 div_borrow;
  logic [TS_W-1:0]      quo_n;
  logic                 out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // edge capture; the fall of an event is taken before its rise
  assign fall_take  = (mode_q == MODE_PULSE) && fall_edge_i && (fall_cnt_q < FALL_MAX);
  assign fall_cnt_n = fall_cnt_q + CNT_W'(fall_take);
  assign rise_take  = (mode_q == MODE_PULSE) && rise_edge_i && (rise_cnt_q < RISE_MAX) &&
                      (fall_cnt_n > rise_cnt_q);

  // pairs = min(rises, falls - 1), zero without falls
  always_comb begin
    if (fall_cnt_q == '0) begin
      pairs_n = '0;
    end else if (rise_cnt_q < fall_cnt_q) begin
      pairs_n = rise_cnt_q;
    end else begin
      pairs_n = fall_cnt_q - CNT_W'(1);
    end
  end

  assign idx_inc    = idx_q + CNT_W'(1);
  assign fall_raddr = (state_q == S_LOAD0) ? '0 : idx_inc[FA_W-1:0];
  assign rise_raddr = idx_q[RA_W-1:0];

  // a difference counts when it is positive as a signed word
  assign w_diff = rise_rd_q - prev_q;
  assign c_diff = fall_rd_q - prev_q;
  assign w_pos  = (w_diff != '0) && !w_diff[TS_W-1];
  assign c_pos  = (c_diff != '0) && !c_diff[TS_W-1];

  // one restoring step; the partial remainder stays below the divisor
  assign div_shift  = {rem_q, quo_q[TS_W-1]};
  assign div_trial  = div_shift - {1'b0, dvsr_q};
  assign div_borrow = div_trial[CNT_W];
  assign quo_n      = {quo_q[TS_W-2:0], !div_borrow};

  always_ff @(posedge clk_i) begin
    if (in_acc && (operation_i == OP_EDGE) && fall_take) begin
      fall_mem[fall_cnt_q[FA_W-1:0]] <= timestamp_i;
    end
    if (in_acc && (operation_i == OP_EDGE) && rise_take) begin
      rise_mem[rise_cnt_q[RA_W-1:0]] <= timestamp_i;
    end
    fall_rd_q <= fall_mem[fall_raddr];
    rise_rd_q <= rise_mem[rise_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_IDLE;
      fall_cnt_q  <= '0;
      rise_cnt_q  <= '0;
      xchk_q      <= '0;
      pairs_q     <= '0;
      idx_q       <= '0;
      prev_q      <= '0;
      wsum_q      <= '0;
      psum_q      <= '0;
      wcnt_q      <= '0;
      pcnt_q      <= '0;
      avg_w_q     <= '0;
      avg_p_q     <= '0;
      div_sel_q   <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      dvsr_q      <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_w_q     <= '0;
      out_p_q     <= '0;
      out_falls_q <= '0;
      out_rises_q <= '0;
      out_xchk_q  <= '0;
      out_done_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        mode_q <= cfg_wr_data_i;
      end
      // in finish the output register is reloaded there instead
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (operation_i)
              OP_EDGE: begin
                if (mode_q == MODE_XCHK) begin
                  xchk_q <= xchk_q + TS_W'(fall_edge_i);
                end
                fall_cnt_q <= fall_cnt_n;
                rise_cnt_q <= rise_cnt_q + CNT_W'(rise_take);
              end
              OP_REPORT: begin
                pairs_q   <= pairs_n;
                idx_q     <= '0;
                wsum_q    <= '0;
                psum_q    <= '0;
                wcnt_q    <= '0;
                pcnt_q    <= '0;
                div_sel_q <= 1'b0;
                state_q   <= (pairs_n == '0) ? S_DSETUP : S_LOAD0;
              end
              OP_CLEAR: begin
                fall_cnt_q <= '0;
                rise_cnt_q <= '0;
                xchk_q     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LOAD0: begin
          state_q <= S_PRIME;
        end
        S_PRIME: begin
          prev_q  <= fall_rd_q;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (w_pos) begin
            wsum_q <= wsum_q + w_diff;
            wcnt_q <= wcnt_q + CNT_W'(1);
          end
          if (c_pos) begin
            psum_q <= psum_q + c_diff;
            pcnt_q <= pcnt_q + CNT_W'(1);
          end
          prev_q  <= fall_rd_q;
          idx_q   <= idx_inc;
          state_q <= (idx_inc == pairs_q) ? S_DSETUP : S_LOAD;
        end
        S_DSETUP: begin
          // zero count gives a zero mean and skips the divider
          if ((div_sel_q ? pcnt_q : wcnt_q) == '0) begin
            if (div_sel_q) begin
              avg_p_q <= '0;
              state_q <= S_FINISH;
            end else begin
              avg_w_q   <= '0;
              div_sel_q <= 1'b1;
            end
          end else begin
            quo_q     <= div_sel_q ? psum_q : wsum_q;
            dvsr_q    <= div_sel_q ? pcnt_q : wcnt_q;
            rem_q     <= '0;
            bit_cnt_q <= '0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q     <= div_borrow ? div_shift[CNT_W-1:0] : div_trial[CNT_W-1:0];
          quo_q     <= quo_n;
          bit_cnt_q <= bit_cnt_q + DIV_CNT_W'(1);
          if (bit_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            if (div_sel_q) begin
              avg_p_q <= quo_n;
              state_q <= S_FINISH;
            end else begin
              avg_w_q   <= quo_n;
              div_sel_q <= 1'b1;
              state_q   <= S_DSETUP;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_w_q     <= avg_w_q;
            out_p_q     <= avg_p_q;
            out_falls_q <= HELD_W'(fall_cnt_q);
            out_rises_q <= HELD_W'(rise_cnt_q);
            out_xchk_q  <= xchk_q;
            out_done_q  <= (fall_cnt_q >= FALL_MAX) && (rise_cnt_q >= RISE_MAX);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign avg_width_o        = out_w_q;
  assign avg_period_o       = out_p_q;
  assign falls_held_o       = out_falls_q;
  assign rises_held_o       = out_rises_q;
  assign crosscheck_falls_o = out_xchk_q;
  assign capture_done_o     = out_done_q;

  `PWPC_ASSERT_IMP(a_rise_le_fall, clk_i, rst_ni, 1'b1, rise_cnt_q <= fall_cnt_q,
                   "more rises held than falls")
  `PWPC_ASSERT_IMP(a_fall_bound, clk_i, rst_ni, 1'b1, fall_cnt_q <= FALL_MAX,
                   "fall count beyond store depth")
  `PWPC_ASSERT_IMP(a_walk_in_range, clk_i, rst_ni, state_q == S_ACC, idx_q < pairs_q,
                   "pair walk past the pair count")
  `PWPC_ASSERT_NXT(a_idle_ignores, clk_i, rst_ni,
                   in_acc && (operation_i == OP_EDGE) && (mode_q == MODE_IDLE),
                   $stable(fall_cnt_q) && $stable(rise_cnt_q) && $stable(xchk_q),
                   "edge request changed counts in idle mode")

endmodule

`default_nettype wire
